>>> design/tvbmm_pkg.sv
// ----------------------------------------------------------------------------
// tvbmm_pkg
// Shared constants, codes and the controller-to-datapath command bundle of
// the TVB minmod slope limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package tvbmm_pkg;

   // defaults for the top-level parameters
   localparam int MAX_CELLS_DEF  = 4096;
   localparam int VALUE_BITS_DEF = 32;

   // result cell index width and multiplier operand cap (magnitude bits)
   localparam int NUM_BITS = 12;
   localparam int MUL_CAP  = 48;

   // sqrt3 and 1/sqrt3 in Q30, split into a high part (c >> 15) and a low part
   localparam logic [30:0] SQRT3_Q30     = 31'd1859775393;
   localparam logic [30:0] INV_SQRT3_Q30 = 31'd619925131;
   localparam logic [15:0] SQRT3_HI      = SQRT3_Q30[30:15];
   localparam logic [14:0] SQRT3_LO      = SQRT3_Q30[14:0];
   localparam logic [15:0] INV_SQRT3_HI  = INV_SQRT3_Q30[30:15];
   localparam logic [14:0] INV_SQRT3_LO  = INV_SQRT3_Q30[14:0];

   // register file
   localparam int          CSR_ADDR_BITS = 4;
   localparam logic [1:0]  REG_ENABLE    = 2'd0;
   localparam logic [1:0]  REG_THRESHOLD = 2'd1;
   localparam logic [1:0]  REG_TOLERANCE = 2'd2;
   localparam logic [30:0] THRESHOLD_RST = 31'd2684355;
   localparam logic [30:0] TOLERANCE_RST = 31'd17;

   // window update on an accepted cell
   typedef enum logic [1:0] {
      WIN_NONE,
      WIN_HEAD,
      WIN_SECOND
   } win_type;

   // operand set of one limiting job
   typedef enum logic [1:0] {
      JOB_A,    // older, pending, incoming cell
      JOB_B,    // older, pending, head (after shift)
      JOB_C     // pending, head, second
   } job_type;

   // source of the emitted slope
   typedef enum logic [1:0] {
      SRC_LIMITED,
      SRC_CUR,
      SRC_HEAD
   } src_type;

   typedef struct packed {
      logic                accept;
      win_type             win;
      logic                load;
      logic                shift;
      job_type             job;
      logic                mul_hi;
      logic                mul_lo;
      logic                rnd;
      logic                minmod;
      logic                finish;
      logic                inv;
      logic                emit;
      src_type             src;
      logic [NUM_BITS-1:0] number;
      logic                status;
      logic                is_last;
   } dp_cmd_type;

endpackage

`default_nettype wire

>>> design/tvbmm_dp.sv
// ----------------------------------------------------------------------------
// tvbmm_dp
// Datapath: cell window, differences, shared Q30 scaling multiplier, minmod
// selection, saturation, change test and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tvbmm_dp
   import tvbmm_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire dp_cmd_type                   cmd,
   input  wire logic signed [VALUE_BITS-1:0] in_average,
   input  wire logic signed [VALUE_BITS-1:0] in_slope,
   input  wire logic                         limiter_enable,
   input  wire logic [30:0]                  tvb_threshold,
   input  wire logic [30:0]                  change_tolerance,
   output logic [NUM_BITS-1:0]               out_cell_number,
   output logic signed [VALUE_BITS-1:0]      out_limited_slope,
   output logic                              out_slope_changed,
   output logic                              out_status,
   output logic                              out_final_result
);

   localparam int VB   = VALUE_BITS;
   localparam int DW   = VB + 1;                          // exact differences
   localparam int MW   = VB + 1;                          // magnitudes
   localparam int MULW = (MW > MUL_CAP) ? MUL_CAP : MW;   // multiplier operand
   localparam int PW   = MULW + 16;                       // partial product
   localparam int SW   = MULW + 32;                       // rounding sum
   localparam int RW   = MULW + 1;                        // rounded product
   localparam int CMPW = (MW > 31) ? MW : 31;

   localparam logic [MW-1:0] OP_CAP = MW'({MULW{1'b1}});
   localparam logic [SW-1:0] HALF   = SW'(64'd1 << 29);
   localparam logic [RW-1:0] VMAX_R = RW'({(VB-1){1'b1}});
   localparam logic [RW-1:0] VMIN_R = VMAX_R + RW'(1);

   function automatic logic [MW-1:0] mag_of(input logic signed [DW-1:0] x);
      logic signed [DW-1:0] n;
      n = -x;
      return x[DW-1] ? MW'(n) : MW'(x);
   endfunction

   function automatic logic [MULW-1:0] cap_op(input logic [MW-1:0] v);
      return (v > OP_CAP) ? {MULW{1'b1}} : v[MULW-1:0];
   endfunction

   // window
   logic signed [VB-1:0] older_ff, pending_ff, pslope_ff;
   logic signed [VB-1:0] head_avg_ff, head_slope_ff, second_ff;
   logic signed [VB-1:0] cur_avg_ff, cur_slope_ff;

   // job working registers
   logic signed [DW-1:0] db_ff, df_ff;
   logic signed [VB-1:0] sl_ff;
   logic [MULW-1:0]      op_ff;
   logic                 neg_ff;
   logic [PW-1:0]        prod_ff, hi_ff;
   logic [RW-1:0]        rnd_ff;
   logic signed [VB-1:0] res_slope_ff;
   logic                 res_chg_ff;

   // result register
   logic [NUM_BITS-1:0]  out_num_ff;
   logic signed [VB-1:0] out_slope_ff;
   logic                 out_chg_ff, out_status_ff, out_last_ff;

   // operand selection
   logic signed [VB-1:0] left_c, mid_c, right_c, slope_c;
   logic signed [DW-1:0] db_in, df_in, slope_x;

   always_comb begin
      case (cmd.job)
         JOB_A: begin
            left_c  = older_ff;
            mid_c   = pending_ff;
            right_c = cur_avg_ff;
            slope_c = pslope_ff;
         end
         JOB_B: begin
            left_c  = older_ff;
            mid_c   = pending_ff;
            right_c = head_avg_ff;
            slope_c = pslope_ff;
         end
         JOB_C: begin
            left_c  = pending_ff;
            mid_c   = head_avg_ff;
            right_c = second_ff;
            slope_c = head_slope_ff;
         end
         default: begin
            left_c  = older_ff;
            mid_c   = pending_ff;
            right_c = cur_avg_ff;
            slope_c = pslope_ff;
         end
      endcase
      db_in   = {mid_c[VB-1], mid_c} - {left_c[VB-1], left_c};
      df_in   = {right_c[VB-1], right_c} - {mid_c[VB-1], mid_c};
      slope_x = {slope_c[VB-1], slope_c};
   end

   // shared scaling multiplier: high coefficient part, then low part
   logic [15:0]   coef_c;
   logic [PW-1:0] prod_in;
   logic [SW-1:0] sum_c;
   logic [RW-1:0] rnd_in;

   always_comb begin
      if (cmd.mul_hi) begin
         coef_c = cmd.inv ? INV_SQRT3_HI : SQRT3_HI;
      end else begin
         coef_c = {1'b0, cmd.inv ? INV_SQRT3_LO : SQRT3_LO};
      end
      prod_in = PW'(op_ff) * PW'(coef_c);
      sum_c   = (SW'(hi_ff) << 15) + SW'(prod_ff) + HALF;
      rnd_in  = sum_c[MULW+30:30];
   end

   // minmod with TVB threshold on a = sqrt3 * slope
   logic [MW-1:0]   a_mag, db_mag, df_mag, k_mag, m_mag;
   logic            a_pos, db_pos, df_pos, m_neg;
   logic [CMPW-1:0] a_cmp, thr_cmp;

   always_comb begin
      a_mag  = MW'(rnd_ff);
      db_mag = mag_of(db_ff);
      df_mag = mag_of(df_ff);
      a_pos  = !neg_ff && (a_mag != '0);
      db_pos = !db_ff[DW-1] && (db_ff != '0);
      df_pos = !df_ff[DW-1] && (df_ff != '0);
      a_cmp  = CMPW'(a_mag);
      thr_cmp = CMPW'(tvb_threshold);
      k_mag  = a_mag;
      if (db_mag < k_mag) begin
         k_mag = db_mag;
      end
      if (df_mag < k_mag) begin
         k_mag = df_mag;
      end
      if (a_cmp < thr_cmp) begin
         m_mag = a_mag;
         m_neg = neg_ff;
      end else if ((a_pos != db_pos) || (db_pos != df_pos)) begin
         m_mag = '0;
         m_neg = 1'b0;
      end else begin
         m_mag = k_mag;
         m_neg = !a_pos;
      end
   end

   // saturate the new slope and test the change
   logic signed [VB-1:0] fresh_c;
   logic signed [DW-1:0] diff_c;
   logic [MW-1:0]        diff_mag;
   logic [CMPW-1:0]      diff_cmp, tol_cmp;
   logic                 chg_c;

   always_comb begin
      if (!neg_ff && (rnd_ff > VMAX_R)) begin
         fresh_c = {1'b0, {(VB-1){1'b1}}};
      end else if (neg_ff && (rnd_ff > VMIN_R)) begin
         fresh_c = {1'b1, {(VB-1){1'b0}}};
      end else if (neg_ff) begin
         fresh_c = -$signed(rnd_ff[VB-1:0]);
      end else begin
         fresh_c = $signed(rnd_ff[VB-1:0]);
      end
      diff_c   = {sl_ff[VB-1], sl_ff} - {fresh_c[VB-1], fresh_c};
      diff_mag = mag_of(diff_c);
      diff_cmp = CMPW'(diff_mag);
      tol_cmp  = CMPW'(change_tolerance);
      chg_c    = limiter_enable && (diff_cmp > tol_cmp);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_avg_ff   <= in_average;
         cur_slope_ff <= in_slope;
         case (cmd.win)
            WIN_HEAD: begin
               head_avg_ff   <= in_average;
               head_slope_ff <= in_slope;
            end
            WIN_SECOND: begin
               second_ff  <= in_average;
               older_ff   <= head_avg_ff;
               pending_ff <= in_average;
               pslope_ff  <= in_slope;
            end
            default: begin
            end
         endcase
      end
      if (cmd.load) begin
         db_ff  <= db_in;
         df_ff  <= df_in;
         sl_ff  <= slope_c;
         op_ff  <= cap_op(mag_of(slope_x));
         neg_ff <= slope_c[VB-1];
      end
      // advance the window once the first job has taken its operands
      if (cmd.shift) begin
         older_ff   <= pending_ff;
         pending_ff <= cur_avg_ff;
         pslope_ff  <= cur_slope_ff;
      end
      if (cmd.mul_hi) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_lo) begin
         hi_ff   <= prod_ff;
         prod_ff <= prod_in;
      end
      if (cmd.rnd) begin
         rnd_ff <= rnd_in;
      end
      if (cmd.minmod) begin
         op_ff  <= cap_op(m_mag);
         neg_ff <= m_neg;
      end
      if (cmd.finish) begin
         res_slope_ff <= chg_c ? fresh_c : sl_ff;
         res_chg_ff   <= chg_c;
      end
      if (cmd.emit) begin
         out_num_ff    <= cmd.number;
         out_status_ff <= cmd.status;
         out_last_ff   <= cmd.is_last;
         case (cmd.src)
            SRC_LIMITED: begin
               out_slope_ff <= res_slope_ff;
               out_chg_ff   <= res_chg_ff;
            end
            SRC_HEAD: begin
               out_slope_ff <= head_slope_ff;
               out_chg_ff   <= 1'b0;
            end
            default: begin
               out_slope_ff <= cur_slope_ff;
               out_chg_ff   <= 1'b0;
            end
         endcase
      end
   end

   assign out_cell_number   = out_num_ff;
   assign out_limited_slope = out_slope_ff;
   assign out_slope_changed = out_chg_ff;
   assign out_status        = out_status_ff;
   assign out_final_result  = out_last_ff;

endmodule

`default_nettype wire

>>> design/tvbmm_ctrl.sv
// ----------------------------------------------------------------------------
// tvbmm_ctrl
// Controller: row position counter, job sequencing for the cells after the
// first two of a row, and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tvbmm_ctrl
   import tvbmm_pkg::*;
#(
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_row_end,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output dp_cmd_type cmd
);

   localparam int CW = $clog2(MAX_CELLS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MHI,
      S_MLO,
      S_RND,
      S_MINMOD,
      S_FINISH,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      R_SHORT0,    // one-cell row
      R_SHORT1A,   // two-cell row, cell 0
      R_SHORT1B,   // two-cell row, cell 1
      R_CELL_A,    // previous cell
      R_CELL_B,    // last cell
      R_CELL_C     // wrapped cell 0
   } res_type;

   state_type     state_ff, state_in;
   res_type       res_ff, res_in;
   logic          pass2_ff, pass2_in;
   logic          end_ff, end_in;
   logic [CW-1:0] cells_ff, cells_in;
   logic [CW-1:0] kk_ff, kk_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic                   accept, out_free;
   logic [CW-1:0]          num_c;
   logic [CW+NUM_BITS-1:0] num_wide;

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      pass2_in     = pass2_ff;
      end_in       = end_ff;
      cells_in     = cells_ff;
      kk_in        = kk_ff;
      rsp_valid_in = rsp_valid_ff;

      accept   = (state_ff == S_IDLE) && req_valid;
      out_free = !rsp_valid_ff || !rsp_stall;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      cmd        = '0;
      cmd.win    = WIN_NONE;
      cmd.job    = JOB_A;
      cmd.src    = SRC_LIMITED;
      cmd.inv    = pass2_ff;

      // emitted fields of the pending result
      num_c = '0;
      case (res_ff)
         R_SHORT0: begin
            cmd.src     = SRC_CUR;
            cmd.status  = 1'b1;
            cmd.is_last = 1'b1;
         end
         R_SHORT1A: begin
            cmd.src    = SRC_HEAD;
            cmd.status = 1'b1;
         end
         R_SHORT1B: begin
            num_c       = CW'(1);
            cmd.src     = SRC_CUR;
            cmd.status  = 1'b1;
            cmd.is_last = 1'b1;
         end
         R_CELL_A: begin
            num_c = kk_ff - CW'(1);
         end
         R_CELL_B: begin
            cmd.job = JOB_B;
            num_c   = (kk_ff >= CW'(MAX_CELLS)) ? CW'(MAX_CELLS - 1) : kk_ff;
         end
         R_CELL_C: begin
            cmd.job     = JOB_C;
            cmd.is_last = 1'b1;
         end
         default: begin
         end
      endcase
      num_wide   = (CW + NUM_BITS)'(num_c);
      cmd.number = num_wide[NUM_BITS-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               end_in     = req_row_end;
               kk_in      = cells_ff;
               if (cells_ff == '0) begin
                  cmd.win = WIN_HEAD;
                  if (req_row_end) begin
                     res_in   = R_SHORT0;
                     state_in = S_EMIT;
                  end else begin
                     cells_in = CW'(1);
                  end
               end else if (cells_ff == CW'(1)) begin
                  cmd.win = WIN_SECOND;
                  if (req_row_end) begin
                     res_in   = R_SHORT1A;
                     state_in = S_EMIT;
                     cells_in = '0;
                  end else begin
                     cells_in = CW'(2);
                  end
               end else begin
                  res_in   = R_CELL_A;
                  state_in = S_LOAD;
                  if (req_row_end) begin
                     cells_in = '0;
                  end else if (cells_ff < CW'(MAX_CELLS)) begin
                     cells_in = cells_ff + CW'(1);
                  end
               end
            end
         end
         S_LOAD: begin
            cmd.load  = 1'b1;
            cmd.shift = (res_ff == R_CELL_A);
            pass2_in  = 1'b0;
            state_in  = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = pass2_ff ? S_FINISH : S_MINMOD;
         end
         S_MINMOD: begin
            cmd.minmod = 1'b1;
            pass2_in   = 1'b1;
            state_in   = S_MHI;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               case (res_ff)
                  R_SHORT1A: begin
                     res_in = R_SHORT1B;
                  end
                  R_CELL_A: begin
                     if (end_ff) begin
                        res_in   = R_CELL_B;
                        state_in = S_LOAD;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  R_CELL_B: begin
                     res_in   = R_CELL_C;
                     state_in = S_LOAD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_ff       <= R_SHORT0;
         pass2_ff     <= 1'b0;
         end_ff       <= 1'b0;
         cells_ff     <= '0;
         kk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff       <= res_in;
         pass2_ff     <= pass2_in;
         end_ff       <= end_in;
         cells_ff     <= cells_in;
         kk_ff        <= kk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/tvb_minmod_slope_limiter.sv
// ----------------------------------------------------------------------------
// tvb_minmod_slope_limiter
// TVB minmod slope limiter for a periodic row of DG cells, with its register
// file, controller and datapath.
//
//   channel | direction | handshake           | beat
//   req     | in        | req_valid/req_stall | cell average, slope, row end
//   rsp     | out       | rsp_valid/rsp_stall | cell number, slope, flags
//   csr     | in/out    | APB psel/penable    | 32-bit register access
//
// The first two cells of a row are taken without a limiting job, and their
// results are emitted directly when the row ends on them. Every later cell
// runs a limiting job: the Q30 scaling runs twice through one shared
// multiplier, in two partial products and a rounding step each. The row end
// runs three such jobs for its three results.
// Reset is synchronous, clears the row position and sets the CSR registers to their reset values.
// A stalled result waits in the output register; the next cell is taken
// meanwhile and its result is held back until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tvb_minmod_slope_limiter
   import tvbmm_pkg::*;
#(
   parameter int MAX_CELLS  = MAX_CELLS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [VALUE_BITS-1:0] req_cell_average,
   input  wire logic signed [VALUE_BITS-1:0] req_cell_slope,
   input  wire logic                         req_row_end,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [NUM_BITS-1:0]               rsp_cell_number,
   output logic signed [VALUE_BITS-1:0]      rsp_limited_slope,
   output logic                              rsp_slope_changed,
   output logic                              rsp_status,
   output logic                              rsp_final_result,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic        enable_ff, enable_in;
   logic [30:0] thr_ff, thr_in;
   logic [30:0] tol_ff, tol_in;
   logic        csr_write;
   logic [1:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      enable_in = enable_ff;
      thr_in    = thr_ff;
      tol_in    = tol_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_ENABLE:    enable_in = csr_pwdata[0];
            REG_THRESHOLD: thr_in    = csr_pwdata[30:0];
            REG_TOLERANCE: tol_in    = csr_pwdata[30:0];
            default: begin
            end
         endcase
      end
      case (reg_sel)
         REG_ENABLE:    csr_prdata = {31'b0, enable_ff};
         REG_THRESHOLD: csr_prdata = {1'b0, thr_ff};
         REG_TOLERANCE: csr_prdata = {1'b0, tol_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         thr_ff    <= THRESHOLD_RST;
         tol_ff    <= TOLERANCE_RST;
      end else begin
         enable_ff <= enable_in;
         thr_ff    <= thr_in;
         tol_ff    <= tol_in;
      end
   end

   dp_cmd_type cmd;

   tvbmm_ctrl #(
      .MAX_CELLS(MAX_CELLS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_row_end(req_row_end),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   tvbmm_dp #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .in_average       (req_cell_average),
      .in_slope         (req_cell_slope),
      .limiter_enable   (enable_ff),
      .tvb_threshold    (thr_ff),
      .change_tolerance (tol_ff),
      .out_cell_number  (rsp_cell_number),
      .out_limited_slope(rsp_limited_slope),
      .out_slope_changed(rsp_slope_changed),
      .out_status       (rsp_status),
      .out_final_result (rsp_final_result)
   );

   // short rows only ever name cells 0 and 1
   a_short_cells: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_cell_number == '0) || (rsp_cell_number == NUM_BITS'(1)))
      else $error("short-row result with cell number above one");

   // a full row closes on the wrapped cell 0
   a_wrap_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_result && !rsp_status |-> rsp_cell_number == '0)
      else $error("row closed on a cell other than cell 0");

   a_short_unchanged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_slope_changed)
      else $error("short-row result marked as limited");

   a_off_unchanged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !enable_ff |-> !rsp_slope_changed)
      else $error("slope changed with the limiter off");

endmodule

`default_nettype wire
